/* rtl/weno5_reconstruction_defines.svh */
`ifndef WENO5_RECONSTRUCTION_DEFINES_SVH
`define WENO5_RECONSTRUCTION_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define W5_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define W5_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/weno5_pkg.sv */
`timescale 1ns / 1ps
package weno5_pkg;

	localparam logic [4:0] OP_NONE = 5'd0;
	localparam logic [4:0] OP_LOAD = 5'd1;
	localparam logic [4:0] OP_SQ1  = 5'd2;
	localparam logic [4:0] OP_SQ2  = 5'd3;
	localparam logic [4:0] OP_BDIV = 5'd4;
	localparam logic [4:0] OP_BCAP = 5'd5;
	localparam logic [4:0] OP_MAX  = 5'd6;
	localparam logic [4:0] OP_NORM = 5'd7;
	localparam logic [4:0] OP_RSQ  = 5'd8;
	localparam logic [4:0] OP_ADIV = 5'd9;
	localparam logic [4:0] OP_ACAP = 5'd10;
	localparam logic [4:0] OP_SUM  = 5'd11;
	localparam logic [4:0] OP_ODIV = 5'd12;
	localparam logic [4:0] OP_OMUL = 5'd13;
	localparam logic [4:0] OP_ACC  = 5'd14;
	localparam logic [4:0] OP_FDIV = 5'd15;
	localparam logic [4:0] OP_FCAP = 5'd16;
	localparam logic [4:0] OP_OUT  = 5'd17;

	localparam logic [63:0] MAX64     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] EPS_RESET = 32'd4295;
	localparam logic        REG_EPSILON = 1'b0;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] k;
		logic       sel;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic norm_more;
	} sts_t;

	function automatic logic [63:0] alpha_num(input logic [1:0] k);
		case (k)
			2'd0: alpha_num = 64'd1 << 60;
			2'd1: alpha_num = 64'd6 << 60;
			2'd2: alpha_num = 64'd3 << 60;
			default: alpha_num = '0;
		endcase
	endfunction

endpackage

/* rtl/weno5_div.sv */
`timescale 1ns / 1ps
module weno5_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic [63:0] quotient,
	output logic        busy
);
	import weno5_pkg::*;

	logic [63:0] rem_q, quo_q, dsr_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [63:0] rem_a, quo_a, rem_b, quo_b;

	function automatic logic [127:0] div_step(input logic [63:0] rem, input logic [63:0] quo,
		input logic [63:0] dsr);
		logic [64:0] r1;
		logic [63:0] rn;
		logic        bit_q;
		r1 = {rem, quo[63]};
		if (r1 >= {1'b0, dsr}) begin
			rn = 64'(r1 - {1'b0, dsr});
			bit_q = 1'b1;
		end else begin
			rn = r1[63:0];
			bit_q = 1'b0;
		end
		div_step = {rn, quo[62:0], bit_q};
	endfunction

	always_comb begin
		{rem_a, quo_a} = div_step(rem_q, quo_q, dsr_q);
		{rem_b, quo_b} = div_step(rem_a, quo_a, dsr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_b;
			quo_q <= quo_b;
		end
	end

	assign quotient = quo_q;
	assign busy = busy_q;

endmodule

module weno5_div3 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	output logic [63:0] quotient,
	output logic        busy
);
	logic [32:0] y_q;
	logic [63:0] p1_q, quo_q;
	logic [31:0] ql_q;
	logic        st1_q, st2_q;
	logic [63:0] p1;
	logic [64:0] ym;
	logic [65:0] p2;

	// x = xh * (3 * 0x5555_5555 + 1) + xl, so x / 3 = xh * 0x5555_5555 + (xh + xl) / 3
	assign p1 = 64'(dividend[63:32]) * 64'(32'h5555_5555);
	assign ym = 65'(y_q) * 65'(32'h5555_5556);
	assign p2 = 66'({y_q, 32'd0}) + 66'(ym);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st1_q <= 1'b0;
			st2_q <= 1'b0;
		end else begin
			st1_q <= start;
			st2_q <= st1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q <= 33'(dividend[63:32]) + 33'(dividend[31:0]);
			p1_q <= p1;
		end
		if (st1_q) ql_q <= p2[65:34];
		if (st2_q) quo_q <= p1_q + 64'(ql_q);
	end

	assign quotient = quo_q;
	assign busy = st1_q | st2_q;

endmodule

/* rtl/weno5_dp.sv */
`timescale 1ns / 1ps
module weno5_dp #(
	parameter int EFF_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  weno5_pkg::cmd_t  cmd,
	output weno5_pkg::sts_t  sts,
	input  logic [31:0]      sample,
	input  logic [31:0]      epsilon,
	output logic [31:0]      left_value,
	output logic [31:0]      right_value
);
	import weno5_pkg::*;

	localparam logic signed [40:0] SAT_HI = 41'((64'sd1 <<< (EFF_BITS - 1)) - 64'sd1);
	localparam logic signed [40:0] SAT_LO = -SAT_HI - 41'sd1;

	logic signed [31:0] win_q [6];
	logic signed [36:0] num_q [3];
	logic [63:0]        den_q [3];
	logic [63:0]        alpha_q [3];
	logic [31:0]        res_q [2];
	logic [31:0]        left_q, right_q;
	logic [63:0]        s1_q;
	logic               sqsat_q, bsat_q, fneg_q, lim_q;
	logic [67:0]        prod_q;
	logic [63:0]        norm_v_q;
	logic [5:0]         norm_cnt_q;
	logic signed [63:0] acc_q;

	logic signed [31:0] x_in;
	logic signed [36:0] sa, sb, sc, sd, se, d1, d2, nm;
	logic [35:0]        m1, m2, mn;
	logic [35:0]        mul_a;
	logic [31:0]        mul_b;
	logic [67:0]        x13;
	logic [65:0]        y3;
	logic [68:0]        zsum;
	logic               bsat;
	logic [64:0]        dsum;
	logic [63:0]        bq, mx, asum, rsh;
	logic [15:0]        r16;
	logic               big, more;
	logic signed [63:0] accr, nsh;
	logic [63:0]        fdvd;
	logic signed [40:0] qv, vv, vs;
	logic               div_start, div_busy;
	logic [63:0]        div_dvd, div_dsr, quo;
	logic               c3_start, c3_busy;
	logic [63:0]        c3_dvd, c3_quo;

	function automatic logic [35:0] mag(input logic signed [36:0] v);
		mag = v[36] ? 36'(-v) : 36'(v);
	endfunction

	assign x_in = 32'($signed(sample[EFF_BITS-1:0]));

	always_comb begin
		if (!cmd.sel) begin
			sa = 37'(win_q[0]); sb = 37'(win_q[1]); sc = 37'(win_q[2]);
			sd = 37'(win_q[3]); se = 37'(win_q[4]);
		end else begin
			sa = 37'(win_q[5]); sb = 37'(win_q[4]); sc = 37'(win_q[3]);
			sd = 37'(win_q[2]); se = 37'(win_q[1]);
		end
	end

	always_comb begin
		d1 = '0;
		d2 = '0;
		nm = '0;
		case (cmd.k)
			2'd0: begin
				d1 = sa - 37'sd2 * sb + sc;
				d2 = sa - 37'sd4 * sb + 37'sd3 * sc;
				nm = 37'sd2 * sa - 37'sd7 * sb + 37'sd11 * sc;
			end
			2'd1: begin
				d1 = sb - 37'sd2 * sc + sd;
				d2 = sb - sd;
				nm = -sb + 37'sd5 * sc + 37'sd2 * sd;
			end
			2'd2: begin
				d1 = sc - 37'sd2 * sd + se;
				d2 = 37'sd3 * sc - 37'sd4 * sd + se;
				nm = 37'sd2 * sc + 37'sd5 * sd - se;
			end
			default: ;
		endcase
	end

	assign m1 = mag(d1);
	assign m2 = mag(d2);
	assign mn = mag(num_q[cmd.k]);

	assign rsh = den_q[cmd.k] >> norm_cnt_q;
	assign r16 = (rsh[15:0] == 16'd0) ? 16'd1 : rsh[15:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ1: begin mul_a = {4'd0, m1[31:0]}; mul_b = m1[31:0]; end
			OP_SQ2: begin mul_a = {4'd0, m2[31:0]}; mul_b = m2[31:0]; end
			OP_RSQ: begin mul_a = 36'(r16); mul_b = 32'(r16); end
			OP_OMUL: begin mul_a = mn; mul_b = quo[31:0]; end
			default: ;
		endcase
	end

	assign x13 = (68'(s1_q) << 3) + (68'(s1_q) << 2) + 68'(s1_q);
	assign y3 = (66'(prod_q[63:0]) << 1) + 66'(prod_q[63:0]);
	assign zsum = 69'(x13) + 69'(y3);
	assign bsat = sqsat_q | (|zsum[68:64]);

	assign bq = bsat_q ? MAX64 : c3_quo;
	assign dsum = 65'(bq) + 65'(epsilon);

	always_comb begin
		mx = den_q[0];
		if (den_q[1] > mx) mx = den_q[1];
		if (den_q[2] > mx) mx = den_q[2];
	end

	assign asum = alpha_q[0] + alpha_q[1] + alpha_q[2];
	assign more = lim_q ? (|norm_v_q[63:24]) : (|norm_v_q[63:16]);
	assign big  = lim_q ? (|norm_v_q[63:32]) : (|norm_v_q[63:24]);

	assign accr = acc_q + 64'sd50331648;
	assign nsh = accr >>> 24;
	assign fdvd = nsh[63] ? 64'(-nsh + 64'sd5) : 64'(nsh);

	assign qv = $signed({1'b0, c3_quo[39:0]});
	assign vv = fneg_q ? -qv : qv;
	assign vs = (vv > SAT_HI) ? SAT_HI : ((vv < SAT_LO) ? SAT_LO : vv);

	always_comb begin
		div_start = 1'b0;
		div_dvd = '0;
		div_dsr = '0;
		case (cmd.op)
			OP_ADIV: begin
				div_start = 1'b1;
				div_dvd = alpha_num(cmd.k);
				div_dsr = prod_q[63:0];
			end
			OP_ODIV: begin
				div_start = 1'b1;
				div_dvd = (alpha_q[cmd.k] >> norm_cnt_q) << 24;
				div_dsr = norm_v_q;
			end
			default: ;
		endcase
	end

	// divide by 12 as (x / 4) / 3, by 6 as (x / 2) / 3
	assign c3_start = (cmd.op == OP_BDIV) || (cmd.op == OP_FDIV);
	assign c3_dvd = (cmd.op == OP_FDIV) ? (fdvd >> 1) : (zsum[63:0] >> 2);

	weno5_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quotient (quo),
		.busy     (div_busy)
	);

	weno5_div3 u_div3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (c3_start),
		.dividend (c3_dvd),
		.quotient (c3_quo),
		.busy     (c3_busy)
	);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: begin
				for (int i = 0; i < 5; i++) win_q[i] <= win_q[i+1];
				win_q[5] <= x_in;
			end
			OP_SQ1: begin
				num_q[cmd.k] <= nm;
				sqsat_q <= |m1[35:32];
			end
			OP_SQ2: begin
				s1_q <= prod_q[63:0];
				sqsat_q <= sqsat_q | (|m2[35:32]);
			end
			OP_BDIV: bsat_q <= bsat;
			OP_BCAP: den_q[cmd.k] <= dsum[64] ? MAX64 : dsum[63:0];
			OP_MAX: begin
				norm_v_q <= mx;
				norm_cnt_q <= '0;
				lim_q <= 1'b0;
			end
			OP_NORM: begin
				if (big) begin
					norm_v_q <= norm_v_q >> 8;
					norm_cnt_q <= norm_cnt_q + 6'd8;
				end else if (more) begin
					norm_v_q <= norm_v_q >> 1;
					norm_cnt_q <= norm_cnt_q + 6'd1;
				end
			end
			OP_ACAP: alpha_q[cmd.k] <= quo;
			OP_SUM: begin
				norm_v_q <= asum;
				norm_cnt_q <= '0;
				lim_q <= 1'b1;
				acc_q <= '0;
			end
			OP_ACC: begin
				if (num_q[cmd.k][36]) acc_q <= acc_q - $signed(prod_q[63:0]);
				else acc_q <= acc_q + $signed(prod_q[63:0]);
			end
			OP_FDIV: fneg_q <= nsh[63];
			OP_FCAP: res_q[cmd.sel] <= vs[31:0];
			OP_OUT: begin
				left_q <= res_q[0];
				right_q <= res_q[1];
			end
			default: ;
		endcase
	end

	assign sts.div_busy = div_busy | c3_busy;
	assign sts.norm_more = more;
	assign left_value = left_q;
	assign right_value = right_q;

endmodule

/* rtl/weno5_ctrl.sv */
`timescale 1ns / 1ps
module weno5_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             line_start,
	input  logic             out_stall,
	input  weno5_pkg::sts_t  sts,
	output weno5_pkg::cmd_t  cmd,
	output logic             in_stall,
	output logic             out_valid
);
	import weno5_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_SQ1   = 5'd1;
	localparam logic [4:0] S_SQ2   = 5'd2;
	localparam logic [4:0] S_BDIV  = 5'd3;
	localparam logic [4:0] S_BWAIT = 5'd4;
	localparam logic [4:0] S_BCAP  = 5'd5;
	localparam logic [4:0] S_MAX   = 5'd6;
	localparam logic [4:0] S_NORMS = 5'd7;
	localparam logic [4:0] S_RSQ   = 5'd8;
	localparam logic [4:0] S_ADIV  = 5'd9;
	localparam logic [4:0] S_AWAIT = 5'd10;
	localparam logic [4:0] S_ACAP  = 5'd11;
	localparam logic [4:0] S_SUM   = 5'd12;
	localparam logic [4:0] S_NORMT = 5'd13;
	localparam logic [4:0] S_ODIV  = 5'd14;
	localparam logic [4:0] S_OWAIT = 5'd15;
	localparam logic [4:0] S_OMUL  = 5'd16;
	localparam logic [4:0] S_ACC   = 5'd17;
	localparam logic [4:0] S_FDIV  = 5'd18;
	localparam logic [4:0] S_FWAIT = 5'd19;
	localparam logic [4:0] S_FCAP  = 5'd20;
	localparam logic [4:0] S_OUT   = 5'd21;

	logic [4:0] state_q, state_d;
	logic [1:0] k_q, k_d;
	logic       sel_q, sel_d;
	logic [2:0] fill_q, fill_d, base, nf;
	logic       ov_q, ov_d;

	assign base = line_start ? 3'd0 : fill_q;
	assign nf = (base < 3'd6) ? base + 3'd1 : 3'd6;

	always_comb begin
		state_d = state_q;
		k_d = k_q;
		sel_d = sel_q;
		fill_d = fill_q;
		ov_d = ov_q & out_stall;
		cmd.op = OP_NONE;
		cmd.k = k_q;
		cmd.sel = sel_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					fill_d = nf;
					if (nf == 3'd6) begin
						state_d = S_SQ1;
						k_d = 2'd0;
						sel_d = 1'b0;
					end
				end
			end
			S_SQ1: begin cmd.op = OP_SQ1; state_d = S_SQ2; end
			S_SQ2: begin cmd.op = OP_SQ2; state_d = S_BDIV; end
			S_BDIV: begin cmd.op = OP_BDIV; state_d = S_BWAIT; end
			S_BWAIT: if (!sts.div_busy) state_d = S_BCAP;
			S_BCAP: begin
				cmd.op = OP_BCAP;
				if (k_q == 2'd2) begin
					state_d = S_MAX;
					k_d = 2'd0;
				end else begin
					state_d = S_SQ1;
					k_d = k_q + 2'd1;
				end
			end
			S_MAX: begin cmd.op = OP_MAX; state_d = S_NORMS; end
			S_NORMS: begin
				if (sts.norm_more) cmd.op = OP_NORM;
				else state_d = S_RSQ;
			end
			S_RSQ: begin cmd.op = OP_RSQ; state_d = S_ADIV; end
			S_ADIV: begin cmd.op = OP_ADIV; state_d = S_AWAIT; end
			S_AWAIT: if (!sts.div_busy) state_d = S_ACAP;
			S_ACAP: begin
				cmd.op = OP_ACAP;
				if (k_q == 2'd2) begin
					state_d = S_SUM;
					k_d = 2'd0;
				end else begin
					state_d = S_RSQ;
					k_d = k_q + 2'd1;
				end
			end
			S_SUM: begin cmd.op = OP_SUM; state_d = S_NORMT; end
			S_NORMT: begin
				if (sts.norm_more) cmd.op = OP_NORM;
				else state_d = S_ODIV;
			end
			S_ODIV: begin cmd.op = OP_ODIV; state_d = S_OWAIT; end
			S_OWAIT: if (!sts.div_busy) state_d = S_OMUL;
			S_OMUL: begin cmd.op = OP_OMUL; state_d = S_ACC; end
			S_ACC: begin
				cmd.op = OP_ACC;
				if (k_q == 2'd2) begin
					state_d = S_FDIV;
					k_d = 2'd0;
				end else begin
					state_d = S_ODIV;
					k_d = k_q + 2'd1;
				end
			end
			S_FDIV: begin cmd.op = OP_FDIV; state_d = S_FWAIT; end
			S_FWAIT: if (!sts.div_busy) state_d = S_FCAP;
			S_FCAP: begin
				cmd.op = OP_FCAP;
				if (!sel_q) begin
					state_d = S_SQ1;
					sel_d = 1'b1;
					k_d = 2'd0;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!ov_q || !out_stall) begin
					cmd.op = OP_OUT;
					ov_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			sel_q <= 1'b0;
			fill_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
			sel_q <= sel_d;
			fill_q <= fill_d;
			ov_q <= ov_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = ov_q;

endmodule

/* rtl/weno5_reconstruction.sv */
`timescale 1ns / 1ps
// channel  handshake              payload
// input    in_valid / in_stall    sample, line_start
// output   out_valid / out_stall  left_value, right_value
// config   psel/penable/pready    epsilon at byte address 0
//
// An item that does not complete the six-value window is only shifted into it.
// An item that completes it needs twelve 64-bit divisions on one shared divider at
// two quotient bits a cycle, eight divisions by 12 or 6, and data-dependent normalize
// shifts.
// Reset sets epsilon to 4295 and clears the fill count and the output valid flag.
// The result waits in the output register; the next item is taken while it stalls.
module weno5_reconstruction #(
	parameter int SAMPLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sample,
	input  logic        line_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] left_value,
	output logic [31:0] right_value,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import weno5_pkg::*;

	localparam int EFF_BITS = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;

	logic [31:0] eps_q;
	cmd_t        cmd;
	sts_t        sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_EPSILON)) begin
			eps_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EPSILON) ? eps_q : 32'd0;

	weno5_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.line_start (line_start),
		.out_stall  (out_stall),
		.sts        (sts),
		.cmd        (cmd),
		.in_stall   (in_stall),
		.out_valid  (out_valid)
	);

	weno5_dp #(
		.EFF_BITS (EFF_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample),
		.epsilon     (eps_q),
		.left_value  (left_value),
		.right_value (right_value)
	);

endmodule

/* rtl/weno5_chk.sv */
`timescale 1ns / 1ps
`include "weno5_reconstruction_defines.svh"
module weno5_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        line_start,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] left_value,
	input logic [31:0] right_value,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic        pready,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	`W5_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(left_value) && $stable(right_value), "stalled result changed")
	`W5_ASSERT_NXT(a_line_start_free, in_valid && !in_stall && line_start, !in_stall, "line start item stalled the input")
	`W5_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(in_stall), "result appeared without computation")
	`W5_ASSERT_NXT(a_eps_readback, psel && penable && pwrite && pready && !paddr[2], paddr[2] || prdata == $past(pwdata), "epsilon readback mismatch")

endmodule

bind weno5_reconstruction weno5_chk u_chk (.*);
